@@ sv/vhr_pkg.sv @@
`timescale 1ns / 1ps
package vhr_pkg;

   // default sizes
   localparam int GRID_DIM_DEFAULT   = 128;
   localparam int WINDOW_DIM_DEFAULT = 1024;

   // field widths
   localparam int PIX_W      = 10;
   localparam int CELL_W     = 7;
   localparam int VEL_W      = 16;
   localparam int WORD_W     = 2 * VEL_W;
   localparam int COLOR_W    = 8;
   localparam int GRID_REG_W = 8;
   localparam int WIN_REG_W  = 11;

   // register port
   localparam int CSR_DW    = 32;
   localparam int CSR_AW    = 4;
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] REG_GRID_WIDTH    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_GRID_HEIGHT   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_WINDOW_WIDTH  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_WINDOW_HEIGHT = 2'd3;
   localparam logic [GRID_REG_W-1:0] GRID_WIDTH_RESET   = 8'd128;
   localparam logic [GRID_REG_W-1:0] GRID_HEIGHT_RESET  = 8'd128;
   localparam logic [WIN_REG_W-1:0]  WINDOW_WIDTH_RESET  = 11'd800;
   localparam logic [WIN_REG_W-1:0]  WINDOW_HEIGHT_RESET = 11'd600;

   // item kinds
   localparam logic ACT_LOAD   = 1'b0;
   localparam logic ACT_RENDER = 1'b1;

   // fixed point
   localparam int MAG_W   = 24;            // floor(sqrt(sq << 16))
   localparam int SQRT_RW = 24;            // root width of the shared sqrt unit
   localparam int DNUM_W  = 44;            // mag * 10 << 16
   localparam int DEN_W   = 26;            // max * 3
   localparam int QS_W    = 17;            // saturated quotient, 0..1.0
   localparam logic [MAG_W-1:0] MAG_FLOOR = 24'd655;
   localparam int ONE_Q16 = 65536;

   // heatmap segments
   localparam logic [1:0] SEG_BLUE_CYAN    = 2'd0;
   localparam logic [1:0] SEG_CYAN_GREEN   = 2'd1;
   localparam logic [1:0] SEG_GREEN_YELLOW = 2'd2;
   localparam logic [1:0] SEG_YELLOW_RED   = 2'd3;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPW = $clog2(QUEUE_DEPTH);

   typedef enum logic [2:0] {
      F_IDLE,
      F_MUL,
      F_DIV,
      F_ADDR,
      F_PUSH
   } front_state_type;

   typedef enum logic [3:0] {
      B_IDLE,
      B_FETCH,
      B_SQUARE,
      B_MAG_GO,
      B_MAG,
      B_DIV,
      B_GAM_GO,
      B_GAM,
      B_OUT
   } back_state_type;

endpackage

@@ sv/vhr_isqrt.sv @@
`timescale 1ns / 1ps
module vhr_isqrt
   import vhr_pkg::*;
#(
   parameter int RW = SQRT_RW,
   localparam int OW = 2 * RW
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [OW-1:0] op,
   output logic          done,
   output logic [RW-1:0] root
);

   localparam int CW = $clog2(RW);

   logic          busy_ff;
   logic          done_ff;
   logic [CW-1:0] cnt_ff;
   logic [OW-1:0] op_ff;
   logic [RW+1:0] rem_ff;
   logic [RW-1:0] root_ff;

   logic [RW+3:0] rem_sh;
   logic [RW+3:0] trial;
   logic          ge;
   logic [RW+1:0] rem_in;
   logic [RW-1:0] root_in;

   // one result bit per step, two operand bits brought down
   always_comb begin
      rem_sh  = {rem_ff, op_ff[OW-1:OW-2]};
      trial   = (RW+4)'({root_ff, 2'b01});
      ge      = rem_sh >= trial;
      rem_in  = ge ? (RW+2)'(rem_sh - trial) : (RW+2)'(rem_sh);
      root_in = {root_ff[RW-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CW'(RW - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         op_ff   <= op;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         op_ff   <= {op_ff[OW-3:0], 2'b00};
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

@@ sv/vhr_front.sv @@
`timescale 1ns / 1ps
module vhr_front
   import vhr_pkg::*;
#(
   parameter int MAX_GRID_DIM = GRID_DIM_DEFAULT,
   parameter int MAX_WINDOW_DIM = WINDOW_DIM_DEFAULT,
   localparam int GDW = $clog2(MAX_GRID_DIM + 1),
   localparam int WDW = $clog2(MAX_WINDOW_DIM + 1),
   localparam int AW = $clog2(MAX_GRID_DIM * MAX_GRID_DIM)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [GDW-1:0]    grid_w,
   input  logic [GDW-1:0]    grid_h,
   input  logic [WDW-1:0]    win_w,
   input  logic [WDW-1:0]    win_h,
   input  logic              req_push,
   output logic              req_full,
   input  logic              req_action,
   input  logic              req_first_cell,
   input  logic [CELL_W-1:0] req_cell_x,
   input  logic [CELL_W-1:0] req_cell_y,
   input  logic [VEL_W-1:0]  req_vel_x,
   input  logic [VEL_W-1:0]  req_vel_y,
   input  logic [PIX_W-1:0]  req_pixel_x,
   input  logic [PIX_W-1:0]  req_pixel_y,
   output logic              cmd_valid,
   input  logic              cmd_ready,
   output logic              cmd_render,
   output logic              cmd_first,
   output logic [AW-1:0]     cmd_addr,
   output logic [WORD_W-1:0] cmd_vel,
   output logic [PIX_W-1:0]  cmd_row,
   output logic [PIX_W-1:0]  cmd_col
);

   localparam int GIW = $clog2(MAX_GRID_DIM);
   localparam int FNW = PIX_W + GDW;
   localparam int CW  = $clog2(FNW);

   front_state_type state_ff, state_in;

   logic              render_ff;
   logic              first_ff;
   logic [AW-1:0]     addr_ff;
   logic [WORD_W-1:0] vel_ff;
   logic [PIX_W-1:0]  row_ff;
   logic [PIX_W-1:0]  px_ff;
   logic [PIX_W-1:0]  py_ff;
   logic [FNW-1:0]    numx_ff;
   logic [FNW-1:0]    numy_ff;
   logic [WDW-1:0]    remx_ff;
   logic [WDW-1:0]    remy_ff;
   logic [CW-1:0]     cnt_ff;

   logic              accept;
   logic              load_hit;
   logic [WDW:0]      rx_sh, ry_sh;
   logic              gex, gey;
   logic [GIW-1:0]    gx, gy;

   assign accept   = req_push && (state_ff == F_IDLE);
   assign load_hit = (int'(req_cell_x) < int'(grid_w)) && (int'(req_cell_y) < int'(grid_h));

   // restoring divide, one quotient bit per cycle on each axis
   always_comb begin
      rx_sh = {remx_ff, numx_ff[FNW-1]};
      ry_sh = {remy_ff, numy_ff[FNW-1]};
      gex   = rx_sh >= {1'b0, win_w};
      gey   = ry_sh >= {1'b0, win_h};
      gx    = (numx_ff >= FNW'(grid_w)) ? GIW'(grid_w - 1'b1) : GIW'(numx_ff);
      gy    = (numy_ff >= FNW'(grid_h)) ? GIW'(grid_h - 1'b1) : GIW'(numy_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd_valid = 1'b0;
      case (state_ff)
         F_IDLE: begin
            if (req_push) begin
               if (req_action == ACT_RENDER) begin
                  state_in = F_MUL;
               end else if (load_hit) begin
                  state_in = F_PUSH;
               end
            end
         end
         F_MUL: state_in = F_DIV;
         F_DIV: begin
            if (cnt_ff == CW'(FNW - 1)) begin
               state_in = F_ADDR;
            end
         end
         F_ADDR: state_in = F_PUSH;
         F_PUSH: begin
            cmd_valid = 1'b1;
            if (cmd_ready) begin
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         render_ff <= req_action;
         first_ff  <= req_first_cell;
         vel_ff    <= {req_vel_y, req_vel_x};
         addr_ff   <= AW'(int'(req_cell_y) * MAX_GRID_DIM + int'(req_cell_x));
         px_ff     <= req_pixel_x;
         py_ff     <= req_pixel_y;
         row_ff    <= PIX_W'(win_h) - PIX_W'(1) - req_pixel_y;
      end
      case (state_ff)
         F_MUL: begin
            numx_ff <= FNW'(px_ff * grid_w);
            numy_ff <= FNW'(py_ff * grid_h);
            remx_ff <= '0;
            remy_ff <= '0;
            cnt_ff  <= '0;
         end
         F_DIV: begin
            remx_ff <= gex ? WDW'(rx_sh - {1'b0, win_w}) : WDW'(rx_sh);
            remy_ff <= gey ? WDW'(ry_sh - {1'b0, win_h}) : WDW'(ry_sh);
            numx_ff <= {numx_ff[FNW-2:0], gex};
            numy_ff <= {numy_ff[FNW-2:0], gey};
            cnt_ff  <= cnt_ff + 1'b1;
         end
         F_ADDR: addr_ff <= AW'(int'(gy) * MAX_GRID_DIM + int'(gx));
         default: ;
      endcase
   end

   assign req_full   = state_ff != F_IDLE;
   assign cmd_render = render_ff;
   assign cmd_first  = first_ff;
   assign cmd_addr   = addr_ff;
   assign cmd_vel    = vel_ff;
   assign cmd_row    = row_ff;
   assign cmd_col    = px_ff;

endmodule

@@ sv/vhr_back.sv @@
`timescale 1ns / 1ps
module vhr_back
   import vhr_pkg::*;
#(
   parameter int MAX_GRID_DIM = GRID_DIM_DEFAULT,
   localparam int AW = $clog2(MAX_GRID_DIM * MAX_GRID_DIM)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               cmd_valid,
   output logic               cmd_ready,
   input  logic               cmd_render,
   input  logic               cmd_first,
   input  logic [AW-1:0]      cmd_addr,
   input  logic [WORD_W-1:0]  cmd_vel,
   input  logic [PIX_W-1:0]   cmd_row,
   input  logic [PIX_W-1:0]   cmd_col,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic [COLOR_W-1:0] rsp_red,
   output logic [COLOR_W-1:0] rsp_green,
   output logic [COLOR_W-1:0] rsp_blue,
   output logic [PIX_W-1:0]   rsp_out_row,
   output logic [PIX_W-1:0]   rsp_out_col
);

   localparam int STORE_DEPTH = MAX_GRID_DIM * MAX_GRID_DIM;
   localparam int DCW = $clog2(DNUM_W);

   // command queue between front and back
   logic              q_render_ff [QUEUE_DEPTH];
   logic              q_first_ff  [QUEUE_DEPTH];
   logic [AW-1:0]     q_addr_ff   [QUEUE_DEPTH];
   logic [WORD_W-1:0] q_vel_ff    [QUEUE_DEPTH];
   logic [PIX_W-1:0]  q_row_ff    [QUEUE_DEPTH];
   logic [PIX_W-1:0]  q_col_ff    [QUEUE_DEPTH];
   logic [QPW-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [QPW:0]      q_cnt_ff;
   logic              q_push, q_pop;

   logic [WORD_W-1:0] store_mem [STORE_DEPTH];
   logic [WORD_W-1:0] rd_data_ff;

   back_state_type state_ff, state_in;

   logic              render_ff;
   logic              first_ff;
   logic [PIX_W-1:0]  row_ff;
   logic [PIX_W-1:0]  col_ff;
   logic [WORD_W-1:0] vel_ff;
   logic [31:0]       sqa_ff, sqb_ff;
   logic [MAG_W-1:0]  max_ff;
   logic [DNUM_W-1:0] dnum_ff;
   logic [DEN_W-1:0]  drem_ff;
   logic [DCW-1:0]    dcnt_ff;

   logic                 out_valid_ff;
   logic [COLOR_W-1:0]   red_ff, green_ff, blue_ff;
   logic [PIX_W-1:0]     out_row_ff, out_col_ff;
   logic                 out_load;

   logic                 sq_start;
   logic [2*SQRT_RW-1:0] sq_op;
   logic                 sq_done;
   logic [SQRT_RW-1:0]   sq_root;

   logic [VEL_W-1:0]  abs_x, abs_y;
   logic [31:0]       sq_sum;
   logic [MAG_W-1:0]  max_floor;
   logic [DEN_W-1:0]  den;
   logic [27:0]       mag10;
   logic [DEN_W:0]    dr_sh;
   logic              dge;
   logic [QS_W-1:0]   q_sat;
   logic [QS_W-1:0]   n;
   logic [QS_W-1:0]   t, t_down;
   logic [24:0]       up_prod, dn_prod;
   logic [1:0]        seg;
   logic [COLOR_W-1:0] up_byte, dn_byte, red_in, green_in, blue_in;

   assign cmd_ready = q_cnt_ff != (QPW+1)'(QUEUE_DEPTH);
   assign q_push    = cmd_valid && cmd_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         q_cnt_ff  <= '0;
      end else begin
         if (q_push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (q_pop) rd_ptr_ff <= rd_ptr_ff + 1'b1;
         q_cnt_ff <= q_cnt_ff + (QPW+1)'(q_push) - (QPW+1)'(q_pop);
      end
   end

   always_ff @(posedge clock) begin
      if (q_push) begin
         q_render_ff[wr_ptr_ff] <= cmd_render;
         q_first_ff[wr_ptr_ff]  <= cmd_first;
         q_addr_ff[wr_ptr_ff]   <= cmd_addr;
         q_vel_ff[wr_ptr_ff]    <= cmd_vel;
         q_row_ff[wr_ptr_ff]    <= cmd_row;
         q_col_ff[wr_ptr_ff]    <= cmd_col;
      end
   end

   // loads write at the head's address, renders read it
   always_ff @(posedge clock) begin
      if (q_pop && q_render_ff[rd_ptr_ff] == ACT_LOAD) begin
         store_mem[q_addr_ff[rd_ptr_ff]] <= q_vel_ff[rd_ptr_ff];
      end
      rd_data_ff <= store_mem[q_addr_ff[rd_ptr_ff]];
   end

   vhr_isqrt #(
      .RW (SQRT_RW)
   ) u_isqrt (
      .clock (clock),
      .reset (reset),
      .start (sq_start),
      .op    (sq_op),
      .done  (sq_done),
      .root  (sq_root)
   );

   always_comb begin
      abs_x     = vel_ff[VEL_W-1] ? VEL_W'(0) - vel_ff[VEL_W-1:0] : vel_ff[VEL_W-1:0];
      abs_y     = vel_ff[WORD_W-1] ? VEL_W'(0) - vel_ff[WORD_W-1:VEL_W]
                                   : vel_ff[WORD_W-1:VEL_W];
      sq_sum    = sqa_ff + sqb_ff;
      max_floor = (max_ff < MAG_FLOOR) ? MAG_FLOOR : max_ff;
      den       = DEN_W'({max_floor, 1'b0}) + DEN_W'(max_floor);
      mag10     = 28'({sq_root[MAG_W-1:0], 3'b000}) + 28'({sq_root[MAG_W-1:0], 1'b0});
      dr_sh     = {drem_ff, dnum_ff[DNUM_W-1]};
      dge       = dr_sh >= {1'b0, den};
      q_sat     = (dnum_ff > DNUM_W'(ONE_Q16)) ? QS_W'(ONE_Q16) : dnum_ff[QS_W-1:0];
   end

   // heatmap: four linear segments on the gamma-corrected value
   always_comb begin
      n       = sq_root[QS_W-1:0];
      t       = n[QS_W-1] ? QS_W'(ONE_Q16) : {1'b0, n[13:0], 2'b00};
      t_down  = QS_W'(ONE_Q16) - t;
      up_prod = {t, 8'h00} - 25'(t);
      dn_prod = {t_down, 8'h00} - 25'(t_down);
      up_byte = up_prod[23:16];
      dn_byte = dn_prod[23:16];
      seg     = n[QS_W-1] ? SEG_YELLOW_RED : n[15:14];
      case (seg)
         SEG_BLUE_CYAN: begin
            red_in = 8'h00; green_in = up_byte; blue_in = 8'hFF;
         end
         SEG_CYAN_GREEN: begin
            red_in = 8'h00; green_in = 8'hFF; blue_in = dn_byte;
         end
         SEG_GREEN_YELLOW: begin
            red_in = up_byte; green_in = 8'hFF; blue_in = 8'h00;
         end
         SEG_YELLOW_RED: begin
            red_in = 8'hFF; green_in = dn_byte; blue_in = 8'h00;
         end
         default: begin
            red_in = 8'hFF; green_in = dn_byte; blue_in = 8'h00;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      q_pop    = 1'b0;
      sq_start = 1'b0;
      sq_op    = '0;
      out_load = 1'b0;
      case (state_ff)
         B_IDLE: begin
            if (q_cnt_ff != '0) begin
               q_pop    = 1'b1;
               state_in = (q_render_ff[rd_ptr_ff] == ACT_RENDER) ? B_FETCH : B_SQUARE;
            end
         end
         B_FETCH:  state_in = B_SQUARE;
         B_SQUARE: state_in = B_MAG_GO;
         B_MAG_GO: begin
            sq_start = 1'b1;
            sq_op    = {sq_sum, 16'h0000};
            state_in = B_MAG;
         end
         B_MAG: begin
            if (sq_done) begin
               state_in = render_ff ? B_DIV : B_IDLE;
            end
         end
         B_DIV: begin
            if (dcnt_ff == DCW'(DNUM_W - 1)) begin
               state_in = B_GAM_GO;
            end
         end
         B_GAM_GO: begin
            sq_start = 1'b1;
            sq_op    = (2*SQRT_RW)'({q_sat, 16'h0000});
            state_in = B_GAM;
         end
         B_GAM: begin
            if (sq_done) begin
               state_in = B_OUT;
            end
         end
         B_OUT: begin
            if (!out_valid_ff || rsp_pop) begin
               out_load = 1'b1;
               state_in = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         render_ff <= q_render_ff[rd_ptr_ff];
         first_ff  <= q_first_ff[rd_ptr_ff];
         row_ff    <= q_row_ff[rd_ptr_ff];
         col_ff    <= q_col_ff[rd_ptr_ff];
         vel_ff    <= q_vel_ff[rd_ptr_ff];
      end
      case (state_ff)
         B_FETCH: vel_ff <= rd_data_ff;
         B_SQUARE: begin
            sqa_ff <= abs_x * abs_x;
            sqb_ff <= abs_y * abs_y;
         end
         B_MAG: begin
            dnum_ff <= {mag10, 16'h0000};
            drem_ff <= '0;
            dcnt_ff <= '0;
         end
         B_DIV: begin
            drem_ff <= dge ? DEN_W'(dr_sh - {1'b0, den}) : DEN_W'(dr_sh);
            dnum_ff <= {dnum_ff[DNUM_W-2:0], dge};
            dcnt_ff <= dcnt_ff + 1'b1;
         end
         default: ;
      endcase
   end

   // running maximum, restarted by a first cell
   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff <= '0;
      end else if (state_ff == B_MAG && sq_done && !render_ff &&
                   (first_ff || sq_root[MAG_W-1:0] > max_ff)) begin
         max_ff <= sq_root[MAG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_pop) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         red_ff     <= red_in;
         green_ff   <= green_in;
         blue_ff    <= blue_in;
         out_row_ff <= row_ff;
         out_col_ff <= col_ff;
      end
   end

   assign rsp_empty   = !out_valid_ff;
   assign rsp_red     = red_ff;
   assign rsp_green   = green_ff;
   assign rsp_blue    = blue_ff;
   assign rsp_out_row = out_row_ff;
   assign rsp_out_col = out_col_ff;

endmodule

@@ sv/velocity_heatmap_renderer_unit.sv @@
`timescale 1ns / 1ps
// Velocity-magnitude heatmap renderer. Load items (action 0) store one grid cell's signed
// Q8.8 velocity pair and update the frame maximum of the magnitude; they give no result and
// out-of-grid loads are dropped. Render items (action 1) map a window pixel to its grid cell,
// normalize the cell's magnitude against 0.3 times the maximum, apply a square-root gamma and
// return blue-cyan-green-yellow-red RGB bytes with the vertically flipped row. The front
// computes the cell with a 1-bit-per-cycle divider (10 + clog2(MAX_GRID_DIM+1) quotient
// bits), and the back runs one shared 24-step square-root unit (once per load, twice per
// render) and a 44-step quotient divider. A two-entry queue lets the front take the next
// item while the back works, and the result register holds a finished pixel until it is
// popped. All cells read by renders must have been loaded first.
module velocity_heatmap_renderer_unit
   import vhr_pkg::*;
#(
   parameter int MAX_GRID_DIM = GRID_DIM_DEFAULT,
   parameter int MAX_WINDOW_DIM = WINDOW_DIM_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic               req_action,
   input  logic               req_first_cell,
   input  logic [CELL_W-1:0]  req_cell_x,
   input  logic [CELL_W-1:0]  req_cell_y,
   input  logic [VEL_W-1:0]   req_vel_x,
   input  logic [VEL_W-1:0]   req_vel_y,
   input  logic [PIX_W-1:0]   req_pixel_x,
   input  logic [PIX_W-1:0]   req_pixel_y,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic [COLOR_W-1:0] rsp_red,
   output logic [COLOR_W-1:0] rsp_green,
   output logic [COLOR_W-1:0] rsp_blue,
   output logic [PIX_W-1:0]   rsp_out_row,
   output logic [PIX_W-1:0]   rsp_out_col,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [CSR_AW-1:0]  csr_paddr,
   input  logic [CSR_DW-1:0]  csr_pwdata,
   output logic [CSR_DW-1:0]  csr_prdata,
   output logic               csr_pready
);

   localparam int GDW = $clog2(MAX_GRID_DIM + 1);
   localparam int WDW = $clog2(MAX_WINDOW_DIM + 1);
   localparam int AW  = $clog2(MAX_GRID_DIM * MAX_GRID_DIM);

   logic [GRID_REG_W-1:0] grid_w_ff, grid_h_ff;
   logic [WIN_REG_W-1:0]  win_w_ff, win_h_ff;
   logic [CSR_IDX_W-1:0]  csr_idx;
   logic                  csr_wr;

   logic [GDW-1:0] grid_w, grid_h;
   logic [WDW-1:0] win_w, win_h;

   logic              cmd_valid, cmd_ready, cmd_render, cmd_first;
   logic [AW-1:0]     cmd_addr;
   logic [WORD_W-1:0] cmd_vel;
   logic [PIX_W-1:0]  cmd_row, cmd_col;

   assign csr_idx    = csr_paddr[CSR_AW-1:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_w_ff <= GRID_WIDTH_RESET;
         grid_h_ff <= GRID_HEIGHT_RESET;
         win_w_ff  <= WINDOW_WIDTH_RESET;
         win_h_ff  <= WINDOW_HEIGHT_RESET;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_GRID_WIDTH:    grid_w_ff <= csr_pwdata[GRID_REG_W-1:0];
            REG_GRID_HEIGHT:   grid_h_ff <= csr_pwdata[GRID_REG_W-1:0];
            REG_WINDOW_WIDTH:  win_w_ff  <= csr_pwdata[WIN_REG_W-1:0];
            REG_WINDOW_HEIGHT: win_h_ff  <= csr_pwdata[WIN_REG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_GRID_WIDTH:    csr_prdata = CSR_DW'(grid_w_ff);
         REG_GRID_HEIGHT:   csr_prdata = CSR_DW'(grid_h_ff);
         REG_WINDOW_WIDTH:  csr_prdata = CSR_DW'(win_w_ff);
         REG_WINDOW_HEIGHT: csr_prdata = CSR_DW'(win_h_ff);
         default:           csr_prdata = '0;
      endcase
   end

   // zero acts as one, anything past the maximum acts as the maximum
   always_comb begin
      grid_w = (grid_w_ff == '0) ? GDW'(1) :
               (int'(grid_w_ff) > MAX_GRID_DIM) ? GDW'(MAX_GRID_DIM) : GDW'(grid_w_ff);
      grid_h = (grid_h_ff == '0) ? GDW'(1) :
               (int'(grid_h_ff) > MAX_GRID_DIM) ? GDW'(MAX_GRID_DIM) : GDW'(grid_h_ff);
      win_w  = (win_w_ff == '0) ? WDW'(1) :
               (int'(win_w_ff) > MAX_WINDOW_DIM) ? WDW'(MAX_WINDOW_DIM) : WDW'(win_w_ff);
      win_h  = (win_h_ff == '0) ? WDW'(1) :
               (int'(win_h_ff) > MAX_WINDOW_DIM) ? WDW'(MAX_WINDOW_DIM) : WDW'(win_h_ff);
   end

   vhr_front #(
      .MAX_GRID_DIM   (MAX_GRID_DIM),
      .MAX_WINDOW_DIM (MAX_WINDOW_DIM)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .grid_w         (grid_w),
      .grid_h         (grid_h),
      .win_w          (win_w),
      .win_h          (win_h),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_action     (req_action),
      .req_first_cell (req_first_cell),
      .req_cell_x     (req_cell_x),
      .req_cell_y     (req_cell_y),
      .req_vel_x      (req_vel_x),
      .req_vel_y      (req_vel_y),
      .req_pixel_x    (req_pixel_x),
      .req_pixel_y    (req_pixel_y),
      .cmd_valid      (cmd_valid),
      .cmd_ready      (cmd_ready),
      .cmd_render     (cmd_render),
      .cmd_first      (cmd_first),
      .cmd_addr       (cmd_addr),
      .cmd_vel        (cmd_vel),
      .cmd_row        (cmd_row),
      .cmd_col        (cmd_col)
   );

   vhr_back #(
      .MAX_GRID_DIM (MAX_GRID_DIM)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd_valid   (cmd_valid),
      .cmd_ready   (cmd_ready),
      .cmd_render  (cmd_render),
      .cmd_first   (cmd_first),
      .cmd_addr    (cmd_addr),
      .cmd_vel     (cmd_vel),
      .cmd_row     (cmd_row),
      .cmd_col     (cmd_col),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_red     (rsp_red),
      .rsp_green   (rsp_green),
      .rsp_blue    (rsp_blue),
      .rsp_out_row (rsp_out_row),
      .rsp_out_col (rsp_out_col)
   );

endmodule

@@ sv/vhr_checker.sv @@
`timescale 1ns / 1ps
module vhr_checker
   import vhr_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               rsp_empty,
   input logic               rsp_pop,
   input logic [COLOR_W-1:0] rsp_red,
   input logic [COLOR_W-1:0] rsp_green,
   input logic [COLOR_W-1:0] rsp_blue,
   input logic [PIX_W-1:0]   rsp_out_row,
   input logic [PIX_W-1:0]   rsp_out_col
);

   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result shown right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_red) && $stable(rsp_green) &&
                                    $stable(rsp_blue) && $stable(rsp_out_row) &&
                                    $stable(rsp_out_col)))
      else $error("waiting result changed before transfer");

   // the heatmap never mixes red and blue
   a_no_red_blue: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_red == 8'h00 || rsp_blue == 8'h00))
      else $error("red and blue both lit");

   // one channel is always full scale
   a_one_full: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_red == 8'hFF || rsp_green == 8'hFF || rsp_blue == 8'hFF))
      else $error("no channel at full scale");

endmodule

bind velocity_heatmap_renderer_unit vhr_checker u_checker (.*);

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
   import vhr_pkg::*;

   localparam int CYCLE_LIMIT = 2000000;
   localparam int DRAIN_CYCLES = 200;
   localparam int GRID_MAX = 128;
   localparam int WIN_MAX = 1024;

   typedef struct {
      logic              action;
      logic              first_cell;
      logic [CELL_W-1:0] cell_x;
      logic [CELL_W-1:0] cell_y;
      logic [VEL_W-1:0]  vel_x;
      logic [VEL_W-1:0]  vel_y;
      logic [PIX_W-1:0]  pixel_x;
      logic [PIX_W-1:0]  pixel_y;
   } cell_item_type;

   typedef struct {
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
      logic [PIX_W-1:0]   row;
      logic [PIX_W-1:0]   col;
   } pixel_type;

   logic               clock;
   logic               reset;
   logic               req_push;
   logic               req_full;
   logic               req_action;
   logic               req_first_cell;
   logic [CELL_W-1:0]  req_cell_x;
   logic [CELL_W-1:0]  req_cell_y;
   logic [VEL_W-1:0]   req_vel_x;
   logic [VEL_W-1:0]   req_vel_y;
   logic [PIX_W-1:0]   req_pixel_x;
   logic [PIX_W-1:0]   req_pixel_y;
   logic               rsp_empty;
   logic               rsp_pop = 1'b0;
   logic [COLOR_W-1:0] rsp_red;
   logic [COLOR_W-1:0] rsp_green;
   logic [COLOR_W-1:0] rsp_blue;
   logic [PIX_W-1:0]   rsp_out_row;
   logic [PIX_W-1:0]   rsp_out_col;
   logic               csr_psel;
   logic               csr_penable;
   logic               csr_pwrite;
   logic [CSR_AW-1:0]  csr_paddr;
   logic [CSR_DW-1:0]  csr_pwdata;
   logic [CSR_DW-1:0]  csr_prdata;
   logic               csr_pready;

   // shadow of the block state
   logic [WORD_W-1:0]     shadow_velocity [GRID_MAX*GRID_MAX];
   logic [31:0]           frame_max;
   logic [GRID_REG_W-1:0] grid_w_reg;
   logic [GRID_REG_W-1:0] grid_h_reg;
   logic [WIN_REG_W-1:0]  win_w_reg;
   logic [WIN_REG_W-1:0]  win_h_reg;

   pixel_type pending_pixels[$];
   int     error_count;
   int     cycle_count;
   int     items_sent;
   int     pop_hold;
   bit     no_idle;

   velocity_heatmap_renderer_unit u_dut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full),
      .req_action(req_action), .req_first_cell(req_first_cell),
      .req_cell_x(req_cell_x), .req_cell_y(req_cell_y),
      .req_vel_x(req_vel_x), .req_vel_y(req_vel_y),
      .req_pixel_x(req_pixel_x), .req_pixel_y(req_pixel_y),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop),
      .rsp_red(rsp_red), .rsp_green(rsp_green), .rsp_blue(rsp_blue),
      .rsp_out_row(rsp_out_row), .rsp_out_col(rsp_out_col),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("** velocity_heatmap_renderer_unit: FAILED **");
         $finish;
      end
   end

   // ---------------------------------------------------------------- predictor

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned root;
      longint unsigned probe;
      root = 0;
      probe = 64'h4000_0000_0000_0000;
      while (probe > v) probe >>= 2;
      while (probe != 0) begin
         if (v >= root + probe) begin
            v -= root + probe;
            root = (root >> 1) + probe;
         end else begin
            root >>= 1;
         end
         probe >>= 2;
      end
      return root;
   endfunction

   function automatic int eff_dim(int raw, int top);
      if (raw == 0) return 1;
      return (raw > top) ? top : raw;
   endfunction

   function automatic longint unsigned speed_q16(logic [VEL_W-1:0] vx, logic [VEL_W-1:0] vy);
      longint unsigned ax;
      longint unsigned ay;
      ax = vx[VEL_W-1] ? (65536 - longint'(vx)) : longint'(vx);
      ay = vy[VEL_W-1] ? (65536 - longint'(vy)) : longint'(vy);
      return int_sqrt((ax * ax + ay * ay) << 16);
   endfunction

   function automatic int grid_col(int px);
      int gw;
      int gx;
      gw = eff_dim(grid_w_reg, GRID_MAX);
      gx = (px * gw) / eff_dim(win_w_reg, WIN_MAX);
      return (gx >= gw) ? gw - 1 : gx;
   endfunction

   function automatic int grid_row(int py);
      int gh;
      int gy;
      gh = eff_dim(grid_h_reg, GRID_MAX);
      gy = (py * gh) / eff_dim(win_h_reg, WIN_MAX);
      return (gy >= gh) ? gh - 1 : gy;
   endfunction

   function automatic pixel_type predict_pixel(cell_item_type it);
      pixel_type       px;
      int              addr;
      longint unsigned mag;
      longint unsigned maxm;
      longint unsigned q;
      longint unsigned n;
      longint unsigned t;
      int              wh;
      addr = grid_row(it.pixel_y) * GRID_MAX + grid_col(it.pixel_x);
      mag = speed_q16(shadow_velocity[addr][15:0], shadow_velocity[addr][31:16]);
      maxm = (frame_max < MAG_FLOOR) ? MAG_FLOOR : frame_max;
      q = ((mag * 10) << 16) / (maxm * 3);
      if (q > ONE_Q16) q = ONE_Q16;
      n = int_sqrt(q << 16);
      if (n > ONE_Q16) n = ONE_Q16;
      if (n < 16384) begin
         t = n * 4;
         px.red = 0; px.green = (t * 255) >> 16; px.blue = 255;
      end else if (n < 32768) begin
         t = (n - 16384) * 4;
         px.red = 0; px.green = 255; px.blue = ((ONE_Q16 - t) * 255) >> 16;
      end else if (n < 49152) begin
         t = (n - 32768) * 4;
         px.red = (t * 255) >> 16; px.green = 255; px.blue = 0;
      end else begin
         t = (n - 49152) * 4;
         px.red = 255; px.green = ((ONE_Q16 - t) * 255) >> 16; px.blue = 0;
      end
      wh = eff_dim(win_h_reg, WIN_MAX);
      px.row = PIX_W'(wh - 1 - int'(it.pixel_y));
      px.col = it.pixel_x;
      return px;
   endfunction

   function automatic void apply_load(cell_item_type it);
      int              addr;
      longint unsigned mag;
      if (it.cell_x >= eff_dim(grid_w_reg, GRID_MAX) ||
          it.cell_y >= eff_dim(grid_h_reg, GRID_MAX)) return;
      addr = int'(it.cell_y) * GRID_MAX + int'(it.cell_x);
      shadow_velocity[addr] = {it.vel_y, it.vel_x};
      mag = speed_q16(it.vel_x, it.vel_y);
      if (it.first_cell || mag > frame_max) frame_max = mag;
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
      error_count++;
   endtask

   always @(posedge clock) begin
      pixel_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_pixels.size() == 0) begin
            report_mismatch("unexpected pixel, row", rsp_out_row, -1);
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_red !== want.red) report_mismatch("red", rsp_red, want.red);
            if (rsp_green !== want.green) report_mismatch("green", rsp_green, want.green);
            if (rsp_blue !== want.blue) report_mismatch("blue", rsp_blue, want.blue);
            if (rsp_out_row !== want.row) report_mismatch("out_row", rsp_out_row, want.row);
            if (rsp_out_col !== want.col) report_mismatch("out_col", rsp_out_col, want.col);
         end
      end
      if (pop_hold > 0) begin
         pop_hold--;
         rsp_pop <= 1'b0;
      end else if (no_idle) begin
         rsp_pop <= 1'b1;
      end else begin
         if ($urandom_range(199) == 0) pop_hold = $urandom_range(20, 80);
         rsp_pop <= ($urandom_range(9) < 7);
      end
   end

   // ---------------------------------------------------------------- stimulus

   function automatic int pick_gap();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // called right after a rising edge; leaves push high when no gap follows
   task automatic send_item(cell_item_type it, int gap);
      req_push       <= 1'b1;
      req_action     <= it.action;
      req_first_cell <= it.first_cell;
      req_cell_x     <= it.cell_x;
      req_cell_y     <= it.cell_y;
      req_vel_x      <= it.vel_x;
      req_vel_y      <= it.vel_y;
      req_pixel_x    <= it.pixel_x;
      req_pixel_y    <= it.pixel_y;
      do @(posedge clock); while (req_full);
      if (it.action == ACT_RENDER) pending_pixels.push_back(predict_pixel(it));
      else apply_load(it);
      items_sent++;
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_load(int cx, int cy, int vx, int vy, bit first, int gap);
      cell_item_type it;
      it = '{ACT_LOAD, first, CELL_W'(cx), CELL_W'(cy), VEL_W'(vx), VEL_W'(vy),
             PIX_W'($urandom), PIX_W'($urandom)};
      send_item(it, gap);
   endtask

   task automatic send_render(int px, int py, int gap);
      cell_item_type it;
      it = '{ACT_RENDER, 1'($urandom), CELL_W'($urandom), CELL_W'($urandom),
             VEL_W'($urandom), VEL_W'($urandom), PIX_W'(px), PIX_W'(py)};
      send_item(it, gap);
   endtask

   task automatic wait_drained();
      req_push <= 1'b0;
      @(posedge clock);
      while (pending_pixels.size() != 0) @(posedge clock);
      // a load in flight leaves nothing to wait on
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, int value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_AW'({idx, 2'b00});
      csr_pwdata  <= CSR_DW'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      case (idx)
         REG_GRID_WIDTH:    grid_w_reg = GRID_REG_W'(value);
         REG_GRID_HEIGHT:   grid_h_reg = GRID_REG_W'(value);
         REG_WINDOW_WIDTH:  win_w_reg = WIN_REG_W'(value);
         REG_WINDOW_HEIGHT: win_h_reg = WIN_REG_W'(value);
         default: ;
      endcase
   endtask

   task automatic set_geometry(int gw, int gh, int ww, int wh);
      csr_write(REG_GRID_WIDTH, gw);
      csr_write(REG_GRID_HEIGHT, gh);
      csr_write(REG_WINDOW_WIDTH, ww);
      csr_write(REG_WINDOW_HEIGHT, wh);
   endtask

   function automatic int rand_velocity();
      logic signed [VEL_W-1:0] v;
      v = VEL_W'($urandom);
      return int'(v >>> $urandom_range(0, 15));
   endfunction

   // load every cell that some pixel of the window can reach
   task automatic load_reachable();
      bit col_hit [GRID_MAX];
      bit row_hit [GRID_MAX];
      bit first;
      first = 1'b1;
      for (int i = 0; i < WIN_MAX; i++) begin
         col_hit[grid_col(i)] = 1'b1;
         row_hit[grid_row(i)] = 1'b1;
      end
      for (int y = 0; y < GRID_MAX; y++)
         for (int x = 0; x < GRID_MAX; x++)
            if (col_hit[x] && row_hit[y]) begin
               send_load(x, y, rand_velocity(), rand_velocity(), first, pick_gap());
               first = 1'b0;
            end
   endtask

   function automatic int count_cols();
      bit hit [GRID_MAX];
      int n;
      n = 0;
      for (int i = 0; i < WIN_MAX; i++) begin
         if (!hit[grid_col(i)]) n++;
         hit[grid_col(i)] = 1'b1;
      end
      return n;
   endfunction

   function automatic int count_rows();
      bit hit [GRID_MAX];
      int n;
      n = 0;
      for (int i = 0; i < WIN_MAX; i++) begin
         if (!hit[grid_row(i)]) n++;
         hit[grid_row(i)] = 1'b1;
      end
      return n;
   endfunction

   function automatic int pick_grid();
      case ($urandom_range(9))
         0: return 0;
         1: return 255;
         2: return 128;
         3: return $urandom_range(129, 254);
         default: return $urandom_range(1, 16);
      endcase
   endfunction

   function automatic int pick_window();
      case ($urandom_range(9))
         0: return 0;
         1: return 2047;
         2: return 1024;
         3: return 1;
         default: return $urandom_range(1, 1100);
      endcase
   endfunction

   function automatic int pick_pixel(int dim);
      if ($urandom_range(1)) return $urandom_range(0, 1023);
      return $urandom_range(0, eff_dim(dim, WIN_MAX) - 1);
   endfunction

   task automatic test_directed();
      set_geometry(2, 2, 4, 4);
      // tiny maximum: the 0.01 floor governs the scale
      send_load(0, 0, 0, 0, 1'b1, 0);
      send_load(1, 0, 1, 1, 1'b0, 0);
      send_load(0, 1, 2, 0, 1'b0, 0);
      send_load(1, 1, -1, 0, 1'b0, 1);
      send_render(2, 0, 0);
      send_render(0, 2, 0);
      send_render(3, 3, 2);
      // full-scale velocities restart the maximum
      send_load(1, 1, -32768, -32768, 1'b1, 0);
      send_load(0, 0, 32767, -32768, 1'b0, 0);
      send_load(1, 0, 4000, 0, 1'b0, 0);
      send_load(0, 1, 12000, -9000, 1'b0, 0);
      // outside the grid: dropped, first_cell ignored
      send_load(127, 0, 0, 0, 1'b1, 0);
      send_load(0, 127, 0, 0, 1'b1, 0);
      send_render(0, 0, 0);
      send_render(3, 3, 0);
      send_render(1023, 1023, 0);
      send_render(2, 0, 0);
      send_render(0, 2, 0);
      send_render(1023, 0, 0);
      send_render(0, 1023, 0);
      send_render(1, 1, 0);
      wait_drained();
   endtask

   task automatic test_backpressure();
      pop_hold = 400;
      for (int i = 0; i < 12; i++) send_render($urandom_range(0, 1023), $urandom_range(0, 1023), 0);
      wait_drained();
   endtask

   task automatic test_random();
      int phase;
      int gw, gh, ww, wh;
      int burst;
      phase = 0;
      while (items_sent < 1550) begin
         gw = pick_grid(); gh = pick_grid(); ww = pick_window(); wh = pick_window();
         if (phase == 0) begin gw = 0; gh = 255; ww = 2047; wh = 0; end
         if (phase == 1) begin gw = 255; gh = 0; ww = 0; wh = 2047; end
         set_geometry(gw, gh, ww, wh);
         // keep the set of reachable cells small
         while (count_cols() > 10) csr_write(REG_WINDOW_WIDTH, $urandom_range(0, 8));
         while (count_rows() > 10) csr_write(REG_WINDOW_HEIGHT, $urandom_range(0, 8));
         no_idle = ($urandom_range(4) == 0);
         load_reachable();
         burst = $urandom_range(20, 45);
         for (int i = 0; i < burst; i++) begin
            if ($urandom_range(9) < 8)
               send_render(pick_pixel(win_w_reg), pick_pixel(win_h_reg), pick_gap());
            else
               send_load($urandom_range(0, 127), $urandom_range(0, 127), rand_velocity(),
                         rand_velocity(), 1'($urandom_range(3) == 0), pick_gap());
         end
         no_idle = 1'b0;
         wait_drained();
         phase++;
      end
   endtask

   initial begin
      reset          <= 1'b1;
      req_push       <= 1'b0;
      req_action     <= ACT_LOAD;
      req_first_cell <= 1'b0;
      req_cell_x     <= '0;
      req_cell_y     <= '0;
      req_vel_x      <= '0;
      req_vel_y      <= '0;
      req_pixel_x    <= '0;
      req_pixel_y    <= '0;
      csr_psel       <= 1'b0;
      csr_penable    <= 1'b0;
      csr_pwrite     <= 1'b0;
      csr_paddr      <= '0;
      csr_pwdata     <= '0;
      error_count = 0;
      cycle_count = 0;
      items_sent = 0;
      pop_hold = 0;
      no_idle = 1'b0;
      frame_max = '0;
      grid_w_reg = GRID_WIDTH_RESET;
      grid_h_reg = GRID_HEIGHT_RESET;
      win_w_reg = WINDOW_WIDTH_RESET;
      win_h_reg = WINDOW_HEIGHT_RESET;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_backpressure();
      test_random();

      if (error_count == 0) begin
         $display("** velocity_heatmap_renderer_unit: PASSED **");
      end else begin
         $display("** velocity_heatmap_renderer_unit: FAILED **");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
sv/vhr_pkg.sv
sv/vhr_isqrt.sv
sv/vhr_front.sv
sv/vhr_back.sv
sv/velocity_heatmap_renderer_unit.sv
sv/vhr_checker.sv
sim/testbench.sv
